[rtl/sliding_window_latency_jitter_macros.svh]
// Assertion macros for the latency and jitter monitor.
// Used by the top level only; no other dependencies.
`ifndef SLIDING_WINDOW_LATENCY_JITTER_MACROS_SVH
`define SLIDING_WINDOW_LATENCY_JITTER_MACROS_SVH

// same-cycle implication, checked outside reset
`define SWLJ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SWLJ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/swlj_pkg.sv]
// Shared constants and interface structs of the latency and jitter monitor.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package swlj_pkg;

    localparam int WINDOW_DEPTH = 16;                    // 2..255
    localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
    localparam int LAT_W        = 24;
    localparam int CNT_W        = 32;
    localparam int SUM_W        = 32;
    localparam int FILL_W       = 8;                     // SUM_W - LAT_W
    localparam int QCNT_W       = $clog2(LAT_W);

    localparam logic [LAT_W-1:0] LAT_ONES = {LAT_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};

    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic [LAT_W-1:0]  wr_data;
        logic              start;
        logic [SLOT_W-1:0] start_addr;
        logic [FILL_W-1:0] count;
    } scan_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] dsum;
        logic [LAT_W-1:0] dmax;
    } scan_res_t;

    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  dividend;
        logic [FILL_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [LAT_W-1:0] quot;
    } div_res_t;

endpackage

`default_nettype wire

[rtl/swlj_scan.sv]
// Sample ring memory and window scanner: writes one sample, then walks the
// held samples oldest to newest, summing values and consecutive differences and
// keeping the largest difference. Depends on swlj_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swlj_scan
    import swlj_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire scan_req_t req,
    output scan_res_t      res
);

    logic [LAT_W-1:0]  ring_mem [WINDOW_DEPTH];
    logic [LAT_W-1:0]  rd_data_reg;

    logic              busy_reg;
    logic [FILL_W-1:0] remain_reg;
    logic [SLOT_W-1:0] rd_addr_reg;
    logic              rvld_reg;
    logic              have_prev_reg;
    logic [LAT_W-1:0]  prev_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  dsum_reg;
    logic [LAT_W-1:0]  dmax_reg;

    logic              rd_en;
    logic              done;
    logic [LAT_W-1:0]  step;

    assign rd_en = busy_reg && (remain_reg != '0);
    assign done  = busy_reg && (remain_reg == '0) && !rvld_reg;
    assign step  = (rd_data_reg > prev_reg) ? (rd_data_reg - prev_reg)
                                            : (prev_reg - rd_data_reg);

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            ring_mem[req.wr_addr] <= req.wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= ring_mem[rd_addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            remain_reg    <= '0;
            rd_addr_reg   <= '0;
            rvld_reg      <= 1'b0;
            have_prev_reg <= 1'b0;
            prev_reg      <= '0;
            sum_reg       <= '0;
            dsum_reg      <= '0;
            dmax_reg      <= '0;
        end
        else if (req.start)
        begin
            busy_reg      <= 1'b1;
            remain_reg    <= req.count;
            rd_addr_reg   <= req.start_addr;
            rvld_reg      <= 1'b0;
            have_prev_reg <= 1'b0;
            sum_reg       <= '0;
            dsum_reg      <= '0;
            dmax_reg      <= '0;
        end
        else
        begin
            rvld_reg <= rd_en;
            if (rd_en)
            begin
                remain_reg  <= remain_reg - 1'b1;
                rd_addr_reg <= (rd_addr_reg == SLOT_W'(WINDOW_DEPTH - 1))
                               ? '0 : rd_addr_reg + 1'b1;
            end
            if (rvld_reg)
            begin
                sum_reg       <= sum_reg + SUM_W'(rd_data_reg);
                prev_reg      <= rd_data_reg;
                have_prev_reg <= 1'b1;
                if (have_prev_reg)
                begin
                    dsum_reg <= dsum_reg + SUM_W'(step);
                    if (step > dmax_reg)
                    begin
                        dmax_reg <= step;
                    end
                end
            end
            if (done)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign res.done = done;
    assign res.sum  = sum_reg;
    assign res.dsum = dsum_reg;
    assign res.dmax = dmax_reg;

endmodule

`default_nettype wire

[rtl/swlj_div.sv]
// Serial restoring divider, one quotient bit per cycle. The caller guarantees
// the quotient fits LAT_W bits, so only LAT_W steps run. Depends on swlj_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swlj_div
    import swlj_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_res_t      res
);

    logic              busy_reg;
    logic              done_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [FILL_W-1:0] rem_reg;
    logic [LAT_W-1:0]  low_reg;
    logic [FILL_W-1:0] divisor_reg;

    logic [FILL_W:0]   cand;
    logic [FILL_W:0]   diff;
    logic              ge;
    logic [FILL_W-1:0] rem_next;

    assign cand     = {rem_reg, low_reg[LAT_W-1]};
    assign diff     = cand - {1'b0, divisor_reg};
    assign ge       = (cand >= {1'b0, divisor_reg});
    // remainder stays below the divisor, so the top bit drops out
    assign rem_next = ge ? diff[FILL_W-1:0] : cand[FILL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
            rem_reg     <= '0;
            low_reg     <= '0;
            divisor_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg    <= 1'b1;
                cnt_reg     <= '0;
                rem_reg     <= req.dividend[SUM_W-1:LAT_W];
                low_reg     <= req.dividend[LAT_W-1:0];
                divisor_reg <= req.divisor;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                low_reg <= {low_reg[LAT_W-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == QCNT_W'(LAT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign res.done = done_reg;
    assign res.quot = low_reg;

endmodule

`default_nettype wire

[rtl/sliding_window_latency_jitter.sv]
// Sliding-window latency and jitter monitor.
//
// Input channel: in_valid / in_stall with probe_ok and latency_us. One request
// is one probe outcome. Output channel: out_valid / out_stall with one result
// request per input request: min, max, window mean, jitter, largest step,
// received and lost counts, and window fill.
//
// A lost probe goes from acceptance straight to the final state, which loads
// its result. A successful probe writes the sample ring memory, scans the held
// samples through the one memory read port, runs the shared serial divider for
// the mean and, with two or more samples held, again for the jitter, then
// loads the result. in_stall is high from acceptance until the result is
// loaded, so no new request is taken until the last result is loaded.
// A finished result waits in the output register while out_stall is high; the
// next input request is accepted meanwhile and its result waits for the
// output register to free up.
// Reset clears all statistics; the minimum resets to all ones. The ring
// memory is not cleared: only written entries are ever read.
// Depends on swlj_pkg, swlj_scan, swlj_div and the macros header.
`timescale 1ns / 1ps
`default_nettype none

`include "sliding_window_latency_jitter_macros.svh"

module sliding_window_latency_jitter
    import swlj_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,

    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic             probe_ok,
    input  wire logic [LAT_W-1:0] latency_us,

    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [LAT_W-1:0]      min_latency_us,
    output logic [LAT_W-1:0]      max_latency_us,
    output logic [LAT_W-1:0]      avg_latency_us,
    output logic [LAT_W-1:0]      jitter_us,
    output logic [LAT_W-1:0]      max_jitter_us,
    output logic [CNT_W-1:0]      received_count,
    output logic [CNT_W-1:0]      lost_count,
    output logic [FILL_W-1:0]     window_fill
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_DIVA = 3'd2;
    localparam logic [2:0] ST_DIVB = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]        state_reg, state_next;

    logic [SLOT_W-1:0] slot_reg;
    logic              full_reg;
    logic [LAT_W-1:0]  min_reg;
    logic [LAT_W-1:0]  max_reg;
    logic [LAT_W-1:0]  widest_reg;
    logic [LAT_W-1:0]  avg_reg;
    logic [LAT_W-1:0]  jit_reg;
    logic [CNT_W-1:0]  ok_cnt_reg;
    logic [CNT_W-1:0]  miss_cnt_reg;
    logic [SUM_W-1:0]  dsum_reg;

    logic              oval_reg;
    logic [LAT_W-1:0]  omin_reg;
    logic [LAT_W-1:0]  omax_reg;
    logic [LAT_W-1:0]  oavg_reg;
    logic [LAT_W-1:0]  ojit_reg;
    logic [LAT_W-1:0]  owide_reg;
    logic [CNT_W-1:0]  ook_reg;
    logic [CNT_W-1:0]  omiss_reg;
    logic [FILL_W-1:0] ofill_reg;

    logic              accept;
    logic              take;
    logic              out_free;
    logic              load_out;
    logic              slot_wrap;
    logic [SLOT_W-1:0] slot_next;
    logic              full_next;
    logic [FILL_W-1:0] fill;
    logic [FILL_W-1:0] fill_next;

    scan_req_t         scan_req;
    scan_res_t         scan_res;
    div_req_t          div_req;
    div_res_t          div_res;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign take      = accept && probe_ok;
    assign out_free  = !oval_reg || !out_stall;
    assign load_out  = (state_reg == ST_FIN) && out_free;

    assign slot_wrap = (slot_reg == SLOT_W'(WINDOW_DEPTH - 1));
    assign slot_next = slot_wrap ? '0 : slot_reg + 1'b1;
    assign full_next = full_reg || slot_wrap;
    assign fill      = full_reg ? FILL_W'(WINDOW_DEPTH) : FILL_W'(slot_reg);
    assign fill_next = full_next ? FILL_W'(WINDOW_DEPTH) : FILL_W'(slot_next);

    // oldest sample sits at the write slot once the ring has wrapped
    always_comb
    begin
        scan_req.wr_en      = take;
        scan_req.wr_addr    = slot_reg;
        scan_req.wr_data    = latency_us;
        scan_req.start      = take;
        scan_req.start_addr = full_next ? slot_next : '0;
        scan_req.count      = fill_next;
    end

    swlj_scan u_scan
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (scan_req),
        .res   (scan_res)
    );

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = scan_res.sum;
        div_req.divisor  = fill;
        if ((state_reg == ST_SCAN) && scan_res.done)
        begin
            div_req.start = 1'b1;
        end
        else if ((state_reg == ST_DIVA) && div_res.done && (fill > FILL_W'(1)))
        begin
            div_req.start    = 1'b1;
            div_req.dividend = dsum_reg;
            div_req.divisor  = fill - 1'b1;
        end
    end

    swlj_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = probe_ok ? ST_SCAN : ST_FIN;
                end
            end
            ST_SCAN:
            begin
                if (scan_res.done)
                begin
                    state_next = ST_DIVA;
                end
            end
            ST_DIVA:
            begin
                if (div_res.done)
                begin
                    state_next = (fill > FILL_W'(1)) ? ST_DIVB : ST_FIN;
                end
            end
            ST_DIVB:
            begin
                if (div_res.done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            slot_reg     <= '0;
            full_reg     <= 1'b0;
            min_reg      <= LAT_ONES;
            max_reg      <= '0;
            widest_reg   <= '0;
            avg_reg      <= '0;
            jit_reg      <= '0;
            ok_cnt_reg   <= '0;
            miss_cnt_reg <= '0;
            dsum_reg     <= '0;
            oval_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (accept && !probe_ok && (miss_cnt_reg != CNT_MAX))
            begin
                miss_cnt_reg <= miss_cnt_reg + 1'b1;
            end

            if (take)
            begin
                if (ok_cnt_reg != CNT_MAX)
                begin
                    ok_cnt_reg <= ok_cnt_reg + 1'b1;
                end
                slot_reg <= slot_next;
                full_reg <= full_next;
                if (latency_us < min_reg)
                begin
                    min_reg <= latency_us;
                end
                if (latency_us > max_reg)
                begin
                    max_reg <= latency_us;
                end
            end

            if ((state_reg == ST_SCAN) && scan_res.done)
            begin
                dsum_reg <= scan_res.dsum;
                if (scan_res.dmax > widest_reg)
                begin
                    widest_reg <= scan_res.dmax;
                end
            end

            if ((state_reg == ST_DIVA) && div_res.done)
            begin
                avg_reg <= div_res.quot;
            end

            if ((state_reg == ST_DIVB) && div_res.done)
            begin
                jit_reg <= div_res.quot;
            end

            if (load_out)
            begin
                oval_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                oval_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            omin_reg  <= min_reg;
            omax_reg  <= max_reg;
            oavg_reg  <= avg_reg;
            ojit_reg  <= jit_reg;
            owide_reg <= widest_reg;
            ook_reg   <= ok_cnt_reg;
            omiss_reg <= miss_cnt_reg;
            ofill_reg <= fill;
        end
    end

    assign out_valid      = oval_reg;
    assign min_latency_us = omin_reg;
    assign max_latency_us = omax_reg;
    assign avg_latency_us = oavg_reg;
    assign jitter_us      = ojit_reg;
    assign max_jitter_us  = owide_reg;
    assign received_count = ook_reg;
    assign lost_count     = omiss_reg;
    assign window_fill    = ofill_reg;

    `SWLJ_ASSERT_NOW(a_out_from_fin, clk, rst_n, $rose(oval_reg), $past(state_reg == ST_FIN), "result loaded outside final state")
    `SWLJ_ASSERT_NOW(a_min_le_max, clk, rst_n, ok_cnt_reg != '0, min_reg <= max_reg, "minimum above maximum after a sample")
    `SWLJ_ASSERT_NOW(a_scan_done_state, clk, rst_n, scan_res.done, state_reg == ST_SCAN, "window scan finished outside scan state")
    `SWLJ_ASSERT_NEXT(a_lost_keeps_fill, clk, rst_n, accept && !probe_ok, $stable(fill), "lost probe changed window fill")

endmodule

`default_nettype wire

[tb/tb_sliding_window_latency_jitter.sv]
`timescale 1ns / 1ps
// Regression bench for the sliding-window latency and jitter monitor.
// Holds its own window/jitter predictor in a scoreboard class; needs swlj_pkg
// and the sliding_window_latency_jitter RTL.

module tb_sliding_window_latency_jitter;
    import swlj_pkg::*;

    localparam int unsigned RANDOM_PROBES = 1525;
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned LONG_HOLD     = 400;
    localparam int unsigned DRAIN_CYCLES  = 100;
    localparam int unsigned ONE_SECOND_US = 999999;

    typedef struct {
        logic [LAT_W-1:0]  min_lat;
        logic [LAT_W-1:0]  max_lat;
        logic [LAT_W-1:0]  avg_lat;
        logic [LAT_W-1:0]  jitter;
        logic [LAT_W-1:0]  max_jitter;
        logic [CNT_W-1:0]  received;
        logic [CNT_W-1:0]  lost;
        logic [FILL_W-1:0] fill;
    } probe_report_t;

    class probe_stats_board;
        logic [LAT_W-1:0] history [WINDOW_DEPTH];
        int unsigned      slot = 0;
        bit               history_full = 1'b0;
        logic [LAT_W-1:0] low_mark = LAT_ONES;
        logic [LAT_W-1:0] high_mark = '0;
        logic [LAT_W-1:0] widest_gap = '0;
        logic [LAT_W-1:0] jitter_now = '0;
        logic [CNT_W-1:0] answered = '0;
        logic [CNT_W-1:0] dropped = '0;
        probe_report_t    pending [$];
        int unsigned      failures = 0;
        int unsigned      reports_checked = 0;

        // Work out the report that one accepted probe request must produce.
        function void note_probe(bit ok, logic [LAT_W-1:0] lat);
            probe_report_t    r;
            int unsigned      held;
            int unsigned      oldest;
            int unsigned      i;
            logic [SUM_W-1:0] total;
            logic [SUM_W-1:0] gap_sum;
            logic [LAT_W-1:0] a;
            logic [LAT_W-1:0] b;
            logic [LAT_W-1:0] gap;

            if (ok)
            begin
                if (answered != CNT_MAX)
                    answered++;
                history[slot] = lat;
                if (slot + 1 == WINDOW_DEPTH)
                begin
                    slot = 0;
                    history_full = 1'b1;
                end
                else
                    slot++;
                if (lat < low_mark)
                    low_mark = lat;
                if (lat > high_mark)
                    high_mark = lat;
            end
            else if (dropped != CNT_MAX)
                dropped++;

            held   = history_full ? WINDOW_DEPTH : slot;
            oldest = (slot + WINDOW_DEPTH - held) % WINDOW_DEPTH;
            total  = '0;
            for (i = 0; i < held; i++)
                total += history[(oldest + i) % WINDOW_DEPTH];

            // jitter only moves on an answered probe with two or more samples
            if (ok && held > 1)
            begin
                gap_sum = '0;
                for (i = 1; i < held; i++)
                begin
                    a   = history[(oldest + i - 1) % WINDOW_DEPTH];
                    b   = history[(oldest + i) % WINDOW_DEPTH];
                    gap = (a > b) ? a - b : b - a;
                    gap_sum += gap;
                    if (gap > widest_gap)
                        widest_gap = gap;
                end
                jitter_now = LAT_W'(gap_sum / (held - 1));
            end

            r.min_lat    = low_mark;
            r.max_lat    = high_mark;
            r.avg_lat    = (held != 0) ? LAT_W'(total / held) : '0;
            r.jitter     = jitter_now;
            r.max_jitter = widest_gap;
            r.received   = answered;
            r.lost       = dropped;
            r.fill       = FILL_W'(held);
            pending.push_back(r);
        endfunction

        function void compare_field(string field, logic [CNT_W-1:0] want,
                                    logic [CNT_W-1:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                failures++;
            end
        endfunction

        function void check_report(probe_report_t got);
            probe_report_t want;

            if (pending.size() == 0)
            begin
                $error("report arrived with no probe request outstanding");
                failures++;
                return;
            end
            want = pending.pop_front();
            reports_checked++;
            compare_field("min_latency_us", want.min_lat, got.min_lat);
            compare_field("max_latency_us", want.max_lat, got.max_lat);
            compare_field("avg_latency_us", want.avg_lat, got.avg_lat);
            compare_field("jitter_us", want.jitter, got.jitter);
            compare_field("max_jitter_us", want.max_jitter, got.max_jitter);
            compare_field("received_count", want.received, got.received);
            compare_field("lost_count", want.lost, got.lost);
            compare_field("window_fill", want.fill, got.fill);
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              probe_ok = 1'b0;
    logic [LAT_W-1:0]  latency_us = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [LAT_W-1:0]  min_latency_us;
    logic [LAT_W-1:0]  max_latency_us;
    logic [LAT_W-1:0]  avg_latency_us;
    logic [LAT_W-1:0]  jitter_us;
    logic [LAT_W-1:0]  max_jitter_us;
    logic [CNT_W-1:0]  received_count;
    logic [CNT_W-1:0]  lost_count;
    logic [FILL_W-1:0] window_fill;

    probe_stats_board board = new();
    bit               calm = 1'b0;
    bit               long_hold_req = 1'b0;

    sliding_window_latency_jitter dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .probe_ok       (probe_ok),
        .latency_us     (latency_us),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .min_latency_us (min_latency_us),
        .max_latency_us (max_latency_us),
        .avg_latency_us (avg_latency_us),
        .jitter_us      (jitter_us),
        .max_jitter_us  (max_jitter_us),
        .received_count (received_count),
        .lost_count     (lost_count),
        .window_fill    (window_fill)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Offer one probe and hold it until the block takes it.
    task automatic send_probe(input bit ok, input logic [LAT_W-1:0] lat);
        in_valid   <= 1'b1;
        probe_ok   <= ok;
        latency_us <= lat;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_probe(ok, lat);
    endtask

    task automatic sender_idle(input int unsigned cycles);
        in_valid <= 1'b0;
        repeat (cycles)
            @(posedge clk);
    endtask

    // Result side: check accepted reports, stall at random or for one long hold.
    initial
    begin : report_sink
        probe_report_t got;
        int unsigned   hold_left;

        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.min_lat    = min_latency_us;
                got.max_lat    = max_latency_us;
                got.avg_lat    = avg_latency_us;
                got.jitter     = jitter_us;
                got.max_jitter = max_jitter_us;
                got.received   = received_count;
                got.lost       = lost_count;
                got.fill       = window_fill;
                board.check_report(got);
            end
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !calm && ($urandom_range(99) < 6);
        end
    end

    initial
    begin : watchdog
        int unsigned cycles;

        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("sliding_window_latency_jitter regression: fail");
        $finish;
    end

    initial
    begin : probe_source
        int unsigned      n;
        int unsigned      i;
        int unsigned      pick;
        logic [LAT_W-1:0] lat;

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: lost probes before any sample, an all-ones first sample,
        // full-scale swings, alternating bit patterns, then wrap the window.
        send_probe(1'b0, LAT_ONES);
        send_probe(1'b0, '0);
        send_probe(1'b1, LAT_ONES);
        send_probe(1'b1, '0);
        send_probe(1'b1, LAT_ONES);
        send_probe(1'b0, 24'h123456);
        send_probe(1'b1, 24'hAAAAAA);
        send_probe(1'b1, 24'h555555);
        send_probe(1'b1, LAT_W'(ONE_SECOND_US));
        send_probe(1'b1, LAT_W'(ONE_SECOND_US + 1));
        send_probe(1'b1, 24'd1);
        for (i = 0; i < 12; i++)
            send_probe(1'b1, (i % 2) ? (LAT_ONES >> i) : LAT_W'(i * 1000));
        send_probe(1'b0, '0);

        for (n = 0; n < RANDOM_PROBES; n++)
        begin
            calm = (n >= 1000 && n < 1300);
            if (n == 300)
                long_hold_req = 1'b1;
            if (n == 800)
            begin
                // let the block drain completely before going on
                in_valid <= 1'b0;
                @(posedge clk);
                while (board.pending.size() != 0)
                    @(posedge clk);
            end
            else if (!calm && $urandom_range(99) < 6)
                sender_idle($urandom_range(1, 4));

            pick = $urandom_range(99);
            lat  = LAT_W'($urandom);
            if (pick < 15)
                send_probe(1'b0, lat);
            else
            begin
                if (pick < 40)
                    lat = LAT_W'($urandom_range(4095));
                else if (pick < 65)
                    lat = LAT_W'($urandom_range(ONE_SECOND_US + 20000,
                                                ONE_SECOND_US - 20000));
                else if (pick >= 92)
                    lat = $urandom_range(1) ? LAT_ONES : '0;
                send_probe(1'b1, lat);
            end
        end

        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Covered %0d answered and %0d lost probes, %0d reports checked,",
                 board.answered, board.dropped, board.reports_checked);
        $display("with window wrap, full-scale latencies, a long output hold and a drain pause.");
        if (board.failures == 0)
            $display("sliding_window_latency_jitter regression: pass");
        else
            $display("sliding_window_latency_jitter regression: fail");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/swlj_pkg.sv
rtl/swlj_scan.sv
rtl/swlj_div.sv
rtl/sliding_window_latency_jitter.sv
tb/tb_sliding_window_latency_jitter.sv
